// ----- rtl/qnt_pkg.sv -----
// Shared types, codes and helpers for the float32 to int8 quantizer.
package qnt_pkg;

    localparam int DIV_STEPS = 25;

    typedef enum logic [1:0] {
        CLS_CALC,
        CLS_ZERO_PT,
        CLS_SAT
    } qnt_cls_t;

    typedef struct packed {
        logic               sgn;
        qnt_cls_t           cls;
        logic signed [11:0] expo;
        logic [25:0]        rem;
        logic [24:0]        quo;
        logic [23:0]        dvs;
    } qnt_div_t;

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found && v[i]) begin
                found = 1'b1;
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

endpackage

// ----- rtl/qnt_unpack.sv -----
// Operand classification, subnormal normalization and divider setup (two stages).
module qnt_unpack (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       x_bits,
    input  logic [31:0]       s_bits,
    output logic              out_valid,
    output qnt_pkg::qnt_div_t out_word
);

    logic             v1_reg;
    logic             sgn1_reg;
    qnt_pkg::qnt_cls_t cls1_reg, cls1_next;
    logic [7:0]       ex1_reg, es1_reg;
    logic [23:0]      mx1_reg, ms1_reg;
    logic [4:0]       lx1_reg, ls1_reg;

    logic x_nan, s_nan, x_inf, s_inf, x_zero, s_zero;
    logic [23:0] mx_in, ms_in;

    assign x_nan  = (x_bits[30:23] == 8'hFF) && (x_bits[22:0] != 23'd0);
    assign s_nan  = (s_bits[30:23] == 8'hFF) && (s_bits[22:0] != 23'd0);
    assign x_inf  = (x_bits[30:23] == 8'hFF) && (x_bits[22:0] == 23'd0);
    assign s_inf  = (s_bits[30:23] == 8'hFF) && (s_bits[22:0] == 23'd0);
    assign x_zero = (x_bits[30:0] == 31'd0);
    assign s_zero = (s_bits[30:0] == 31'd0);
    assign mx_in  = {x_bits[30:23] != 8'd0, x_bits[22:0]};
    assign ms_in  = {s_bits[30:23] != 8'd0, s_bits[22:0]};

    always_comb begin
        priority if (x_nan || s_nan) begin
            cls1_next = qnt_pkg::CLS_ZERO_PT;
        end else if (s_zero) begin
            cls1_next = x_zero ? qnt_pkg::CLS_ZERO_PT : qnt_pkg::CLS_SAT;
        end else if (x_inf) begin
            cls1_next = s_inf ? qnt_pkg::CLS_ZERO_PT : qnt_pkg::CLS_SAT;
        end else if (s_inf || x_zero) begin
            cls1_next = qnt_pkg::CLS_ZERO_PT;
        end else begin
            cls1_next = qnt_pkg::CLS_CALC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            sgn1_reg <= x_bits[31] ^ s_bits[31];
            cls1_reg <= cls1_next;
            ex1_reg  <= x_bits[30:23];
            es1_reg  <= s_bits[30:23];
            mx1_reg  <= mx_in;
            ms1_reg  <= ms_in;
            lx1_reg  <= qnt_pkg::lzc24(mx_in);
            ls1_reg  <= qnt_pkg::lzc24(ms_in);
        end
    end

    logic [23:0]        mx_n, ms_n;
    logic signed [9:0]  ex_eff, es_eff;
    logic signed [11:0] e_diff;
    logic               v2_reg;
    qnt_pkg::qnt_div_t  w2_reg, w2_next;

    always_comb begin
        mx_n   = mx1_reg << lx1_reg;
        ms_n   = ms1_reg << ls1_reg;
        ex_eff = $signed({2'b00, (ex1_reg == 8'd0) ? 8'd1 : ex1_reg}) -
                 $signed({5'd0, lx1_reg});
        es_eff = $signed({2'b00, (es1_reg == 8'd0) ? 8'd1 : es1_reg}) -
                 $signed({5'd0, ls1_reg});
        e_diff = 12'(ex_eff) - 12'(es_eff);
        w2_next.sgn = sgn1_reg;
        w2_next.cls = cls1_reg;
        w2_next.quo = 25'd0;
        w2_next.dvs = ms_n;
        if (mx_n >= ms_n) begin
            w2_next.rem  = {2'b00, mx_n};
            w2_next.expo = e_diff;
        end else begin
            w2_next.rem  = {1'b0, mx_n, 1'b0};
            w2_next.expo = e_diff - 12'sd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            w2_reg <= w2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_word  = w2_reg;

endmodule

// ----- rtl/qnt_div_step.sv -----
// One registered restoring-division step: one quotient bit per stage.
module qnt_div_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  qnt_pkg::qnt_div_t in_word,
    output logic              out_valid,
    output qnt_pkg::qnt_div_t out_word
);

    logic              v_reg;
    qnt_pkg::qnt_div_t w_reg, w_next;
    logic [25:0]       diff;
    logic              take;

    always_comb begin
        take   = in_word.rem >= {2'b00, in_word.dvs};
        diff   = take ? (in_word.rem - {2'b00, in_word.dvs}) : in_word.rem;
        w_next = in_word;
        w_next.rem = {diff[24:0], 1'b0};
        w_next.quo = {in_word.quo[23:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
        if (en) begin
            w_reg <= w_next;
        end
    end

    assign out_valid = v_reg;
    assign out_word  = w_reg;

endmodule

// ----- rtl/qnt_round.sv -----
// Float rounding of the quotient, integer rounding, zero point add and saturation.
module qnt_round (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  qnt_pkg::qnt_div_t in_word,
    input  logic [7:0]        zero_point,
    input  logic              signed_mode,
    output logic              out_valid,
    output logic [7:0]        out_byte
);

    // stage A: round quotient to 24 bits, nearest even
    logic               va_reg, sgna_reg;
    qnt_pkg::qnt_cls_t  clsa_reg;
    logic signed [11:0] ea_reg, ea_next;
    logic [23:0]        ma_reg, ma_next;
    logic [24:0]        m_sum;
    logic               inc;

    always_comb begin
        inc   = in_word.quo[0] & ((in_word.rem != 26'd0) | in_word.quo[1]);
        m_sum = {1'b0, in_word.quo[24:1]} + {24'd0, inc};
        if (m_sum[24]) begin
            ma_next = 24'h800000;
            ea_next = in_word.expo + 12'sd1;
        end else begin
            ma_next = m_sum[23:0];
            ea_next = in_word.expo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
        end
        if (en) begin
            sgna_reg <= in_word.sgn;
            clsa_reg <= in_word.cls;
            ea_reg   <= ea_next;
            ma_reg   <= ma_next;
        end
    end

    // stage B: round to integer magnitude, ties to even
    logic               vb_reg, sgnb_reg;
    qnt_pkg::qnt_cls_t  clsb_reg, clsb_next;
    logic [9:0]         magb_reg, magb_next;
    logic signed [11:0] sh_full;
    logic [4:0]         sh;
    logic [23:0]        t_full, rest_mask;
    logic               half, rest;

    always_comb begin
        sh_full   = 12'sd23 - ea_reg;
        sh        = sh_full[4:0];
        t_full    = ma_reg >> sh;
        half      = ma_reg[sh - 5'd1];
        rest_mask = (24'd1 << (sh - 5'd1)) - 24'd1;
        rest      = (ma_reg & rest_mask) != 24'd0;
        clsb_next = clsa_reg;
        magb_next = 10'd0;
        if (clsa_reg == qnt_pkg::CLS_CALC) begin
            priority if (ea_reg > 12'sd8) begin
                clsb_next = qnt_pkg::CLS_SAT;
            end else if (ea_reg < -12'sd1) begin
                magb_next = 10'd0;
            end else begin
                magb_next = t_full[9:0] + {9'd0, half & (rest | t_full[0])};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
        if (en) begin
            sgnb_reg <= sgna_reg;
            clsb_reg <= clsb_next;
            magb_reg <= magb_next;
        end
    end

    // stage C: add zero point, clamp
    logic               vc_reg;
    logic [7:0]         bc_reg;
    logic [7:0]         bc_next;
    logic signed [10:0] zpv, lo, hi, smag, sum, clamped;

    always_comb begin
        zpv  = signed_mode ? 11'($signed(zero_point)) : {3'b000, zero_point};
        lo   = signed_mode ? -11'sd128 : 11'sd0;
        hi   = signed_mode ? 11'sd127 : 11'sd255;
        smag = sgnb_reg ? -$signed({1'b0, magb_reg}) : $signed({1'b0, magb_reg});
        sum  = smag + zpv;
        unique case (clsb_reg)
            qnt_pkg::CLS_SAT:     clamped = sgnb_reg ? lo : hi;
            qnt_pkg::CLS_CALC: begin
                priority if (sum < lo) begin
                    clamped = lo;
                end else if (sum > hi) begin
                    clamped = hi;
                end else begin
                    clamped = sum;
                end
            end
            default:              clamped = zpv;
        endcase
        bc_next = clamped[7:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= vb_reg;
        end
        if (en) begin
            bc_reg <= bc_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_byte  = bc_reg;

endmodule

// ----- rtl/float_to_int8_linear_quantizer_top.sv -----
// Top level of the float32 to int8 linear quantizer pipeline.
//
//  channel   dir  word
//  s_        in   tdata[31:0] sample_bits (float32)
//  m_        out  tdata[7:0]  quant_byte
//  cfg_      in   index 0 scale_bits, 1 zero_point_byte, 2 signed_mode
//
// One word per cycle while the output is not stalled; stages: 2 unpack, 25 divider bit stages, 3 round.
// The divider, one quotient bit per stage, sets the depth.
// Reset (aresetn low, synchronous) clears valid bits and loads register defaults.
// The whole pipeline holds while m_tvalid is high and m_tready low.
module float_to_int8_linear_quantizer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] quant_byte
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic [1:0] REG_SCALE = 2'd0;
    localparam logic [1:0] REG_ZP    = 2'd1;
    localparam logic [1:0] REG_MODE  = 2'd2;

    logic [31:0] scale_reg;
    logic [7:0]  zp_reg;
    logic        mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= 32'h3F800000;
            zp_reg    <= 8'd0;
            mode_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SCALE: scale_reg <= cfg_data;
                REG_ZP:    zp_reg    <= cfg_data[7:0];
                REG_MODE:  mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic              vld [qnt_pkg::DIV_STEPS+1];
    qnt_pkg::qnt_div_t wrd [qnt_pkg::DIV_STEPS+1];

    qnt_unpack u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .x_bits    (s_tdata),
        .s_bits    (scale_reg),
        .out_valid (vld[0]),
        .out_word  (wrd[0])
    );

    for (genvar g = 0; g < qnt_pkg::DIV_STEPS; g++) begin : g_div
        qnt_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (vld[g]),
            .in_word   (wrd[g]),
            .out_valid (vld[g+1]),
            .out_word  (wrd[g+1])
        );
    end

    qnt_round u_round (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (vld[qnt_pkg::DIV_STEPS]),
        .in_word     (wrd[qnt_pkg::DIV_STEPS]),
        .zero_point  (zp_reg),
        .signed_mode (mode_reg),
        .out_valid   (m_tvalid),
        .out_byte    (m_tdata)
    );

endmodule

// ----- tb/tb_float_to_int8_linear_quantizer_top.sv -----
// Self-checking testbench for the float32 to int8 linear quantizer.
`timescale 1ns / 1ps

module tb_float_to_int8_linear_quantizer_top;

    localparam logic [1:0] REG_SCALE  = 2'd0;
    localparam logic [1:0] REG_ZP     = 2'd1;
    localparam logic [1:0] REG_SIGNED = 2'd2;
    localparam int LATENCY   = 30;
    localparam int WDOG_MAX  = 5000;
    localparam int HOLD_LEN  = 300;

    class quant_scoreboard;
        logic [7:0] expected_q[$];
        int mismatches = 0;
        int orphans = 0;
        int checked = 0;

        function void note_word(logic [7:0] q);
            expected_q.push_back(q);
        endfunction

        function void check_word(logic [7:0] got);
            logic [7:0] want;
            if (expected_q.size() == 0) begin
                orphans++;
                $display("unexpected output word %h", got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("quant_byte mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic [31:0] scale_reg = 32'h3F80_0000;
    logic [7:0]  zp_reg = 8'h00;
    logic        signed_reg = 1'b0;

    quant_scoreboard sb = new();
    bit hold_req = 0;
    int idle_cycles = 0;
    int sent = 0;

    always #5 aclk = ~aclk;

    float_to_int8_linear_quantizer_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic real bits_to_real(logic [31:0] b);
        real v;
        if (b[30:23] == 8'd0)
            v = real'(b[22:0]) * 2.0 ** (-149.0);
        else
            v = real'({1'b1, b[22:0]}) * 2.0 ** (real'(b[30:23]) - 150.0);
        return b[31] ? -v : v;
    endfunction

    function automatic real round_half_even(real m);
        real fl, d;
        fl = $floor(m);
        d = m - fl;
        if (d > 0.5 || (d == 0.5 && $floor(fl / 2.0) * 2.0 != fl))
            fl = fl + 1.0;
        return fl;
    endfunction

    // round a double quotient to single precision (only matters for |q| >= 0.25)
    function automatic real to_single(real qd);
        logic [63:0] db;
        int e;
        real ulp;
        if (qd < 0.25 && qd > -0.25)
            return 0.0;
        db = $realtobits(qd);
        e = int'(db[62:52]) - 1023;
        ulp = 2.0 ** real'(e - 23);
        return round_half_even(qd / ulp) * ulp;
    endfunction

    function automatic logic [7:0] quantize(logic [31:0] x);
        int zp, lo, hi, v;
        bit x_nan, s_nan, x_inf, s_inf, s_zero, x_zero;
        real q;
        if (signed_reg) begin
            zp = int'($signed(zp_reg)); lo = -128; hi = 127;
        end else begin
            zp = int'(zp_reg); lo = 0; hi = 255;
        end
        x_nan = x[30:23] == 8'hFF && x[22:0] != 0;
        s_nan = scale_reg[30:23] == 8'hFF && scale_reg[22:0] != 0;
        x_inf = x[30:0] == 31'h7F80_0000;
        s_inf = scale_reg[30:0] == 31'h7F80_0000;
        x_zero = x[30:0] == 0;
        s_zero = scale_reg[30:0] == 0;
        if (x_nan || s_nan || (x_inf && s_inf) || (x_zero && s_zero))
            return 8'(zp);
        if (x_inf || s_zero)
            return (x[31] ^ scale_reg[31]) ? 8'(lo) : 8'(hi);
        if (s_inf)
            return 8'(zp);
        q = to_single(bits_to_real(x) / bits_to_real(scale_reg));
        if (q >= 512.0)
            v = hi;
        else if (q <= -512.0)
            v = lo;
        else begin
            v = int'(round_half_even(q)) + zp;
            if (v < lo) v = lo;
            else if (v > hi) v = hi;
        end
        return 8'(v);
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_word(quantize(s_tdata));
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (sb.expected_q.size() == 0 && !s_tvalid))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("watchdog expired with %0d words pending", sb.expected_q.size());
                $display("tb_float_to_int8_linear_quantizer_top: errors");
                $finish;
            end
        end
    end

    // receiver stall pattern, plus one long hold-off on request
    initial begin
        int mode;
        mode = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(negedge aclk);
                hold_req = 0;
            end
            if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1; cfg_index = idx; cfg_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_SCALE:  scale_reg = val;
            REG_ZP:     zp_reg = val[7:0];
            REG_SIGNED: signed_reg = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] scale, logic [7:0] zp, logic sgn);
        wait (sb.expected_q.size() == 0);
        repeat (LATENCY + 10) @(negedge aclk);
        write_reg(REG_SCALE, scale);
        write_reg(REG_ZP, {24'($urandom_range(0, 16777215)), zp});
        write_reg(REG_SIGNED, {31'($urandom), sgn});
    endtask

    // drive one word; valid stays high across a burst
    task automatic send_word(logic [31:0] w);
        s_tvalid = 1'b1;
        s_tdata = w;
        do @(posedge aclk); while (!s_tready);
        sent++;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_sample(logic [31:0] scale);
        int e, se;
        se = (scale[30:23] == 0 || scale[30:23] == 8'hFF) ? 127 : int'(scale[30:23]);
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(0, 3))};
            3: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
            default: begin
                e = se + $urandom_range(0, 10) - 3;
                if (e < 1) e = 1;
                if (e > 254) e = 254;
                return {$urandom_range(0, 1) == 1, 8'(e),
                        $urandom_range(0, 1) ? 23'($urandom)
                                             : {3'($urandom_range(0, 7)), 20'h0}};
            end
        endcase
    endfunction

    task automatic run_random(int n, logic [31:0] scale);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && n > 0) begin
                send_word(rand_sample(scale));
                burst--; n--;
            end
            s_tvalid = 1'b0;
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid = 1'b0;
    endtask

    logic [31:0] directed[] = '{
        32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
        32'h3F00_0000, 32'hBF00_0000, 32'h3FC0_0000, 32'h4020_0000,
        32'h42FE_0000, 32'h4300_0000, 32'hC300_0000, 32'h437F_0000,
        32'h4400_0000, 32'hC400_0000, 32'h43FF_FFFF, 32'h7F80_0000,
        32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001,
        32'h0000_0001, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3EFF_FFFF
    };

    task automatic run_directed();
        foreach (directed[i])
            send_word(directed[i]);
        s_tvalid = 1'b0;
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        run_directed();
        set_config(32'h3F80_0000, 8'h80, 1'b1);
        run_directed();
        set_config(32'h3F00_0000, 8'hFF, 1'b0);
        run_random(100, scale_reg);
        set_config(32'h0000_0000, 8'h7F, 1'b1);
        run_directed();
        run_random(40, scale_reg);
        set_config(32'h8000_0000, 8'h05, 1'b0);
        run_random(40, scale_reg);
        set_config(32'h7F80_0000, 8'h33, 1'b1);
        run_directed();
        set_config(32'h7FC0_0000, 8'hC0, 1'b1);
        run_random(30, scale_reg);
        set_config(32'hFFFF_FFFF, 8'h01, 1'b0);
        run_random(20, scale_reg);
        set_config(32'h0000_0001, 8'h00, 1'b0);
        run_random(30, scale_reg);
        set_config(32'hBE80_0000, 8'h80, 1'b1);
        hold_req = 1;
        run_random(120, scale_reg);
        for (int p = 0; p < 5; p++) begin
            set_config({$urandom_range(0, 1) == 1, 8'($urandom_range(115, 135)), 23'($urandom)},
                       8'($urandom), $urandom_range(0, 1));
            run_random(100, scale_reg);
        end

        wait (sb.expected_q.size() == 0);
        repeat (LATENCY + 20) @(negedge aclk);
        $display("sent %0d samples, checked %0d bytes over scales incl. zero, inf, NaN",
                 sent, sb.checked);
        $display("signed and unsigned modes, zero points at both ends, long output stall");
        if (sb.mismatches == 0 && sb.orphans == 0 && sb.expected_q.size() == 0)
            $display("tb_float_to_int8_linear_quantizer_top: clean");
        else
            $display("tb_float_to_int8_linear_quantizer_top: errors");
        $finish;
    end

endmodule
